// ===== src/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, constants and helpers of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 20;
    localparam int MIN_HEAP     = HEADER_BYTES + 8;
    localparam int OFF_W        = 16;
    localparam int HEAP_W       = 17;
    localparam int WORD_BYTES   = 4;
    localparam int DEPTH        = HEAP_BYTES / WORD_BYTES;
    localparam int ADDR_W       = $clog2(DEPTH);

    typedef logic [OFF_W-1:0]  off_t;
    typedef logic [HEAP_W-1:0] heap_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_ZERO    = 3'd1,
        STAT_OOM     = 3'd2,
        STAT_NULL    = 3'd3,
        STAT_INVALID = 3'd4,
        STAT_DOUBLE  = 3'd5
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } command_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_WALK,
        S_A_SPLIT,
        S_F_HEAD,
        S_F_NEXT,
        S_F_HW,
        S_F_WALK,
        S_F_PW
    } state_t;

    // one block header: current block start, free mark, payload bytes
    typedef struct packed {
        logic used;
        logic free;
        off_t size;
    } entry_t;

    typedef struct packed {
        logic  command;
        off_t  request_bytes;
        off_t  free_offset;
    } cmd_t;

    typedef struct packed {
        off_t    payload_offset;
        status_t status;
    } res_t;

    typedef struct packed {
        logic   we;
        addr_t  waddr;
        entry_t wdata;
        addr_t  raddr;
    } mem_req_t;

    function automatic addr_t addr_of(input off_t off);
        return off[OFF_W-1:OFF_W-ADDR_W];
    endfunction

    function automatic entry_t mk_entry(input logic used, input logic free, input off_t size);
        entry_t e;
        e.used = used;
        e.free = free;
        e.size = size;
        return e;
    endfunction

endpackage

// ===== src/ffha_if.sv =====
// ----------------------------------------------------------------------------
// ffha channels
// Valid/ready channels of the allocator: commands, results, heap size.
// ----------------------------------------------------------------------------
interface ffha_cmd_if;
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [15:0]          request_bytes;
    logic [15:0]          free_offset;
    modport source (output valid, command, request_bytes, free_offset, input ready);
    modport sink   (input valid, command, request_bytes, free_offset, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] payload_offset;
    logic [2:0]  status;
    modport source (output valid, payload_offset, status, input ready);
    modport sink   (input valid, payload_offset, status, output ready);
endinterface

interface ffha_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] heap_size;
    modport source (output valid, heap_size, input ready);
    modport sink   (input valid, heap_size, output ready);
endinterface

// ===== src/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with block splitting and coalescing on free.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                          | transfer
//  --------+-----+----------------------------------+----------------------
//  cfg     | in  | heap_size                        | valid & ready
//  cmd     | in  | command, request_bytes,          | valid & ready
//          |     | free_offset                      |
//  rsp     | out | payload_offset, status           | valid & ready
//
//  Cycles: headers sit in one synchronous store, one per 4-byte word. An
//  allocate takes 1 cycle plus one per block walked, plus one if it splits; a
//  free takes 2 to 4, plus one per block walked to find the previous
//  neighbour and one if it merges with it; rejected words take 1.
//  Reset and each heap_size write clear the store for 16384 cycles; cmd not ready.
//  Stalls: a spare slot behind the output register takes a result while rsp waits.
//
module first_fit_heap_allocator (
    input logic        clk,
    input logic        rst_n,
    ffha_cfg_if.sink   cfg,
    ffha_cmd_if.sink   cmd,
    ffha_rsp_if.source rsp
);
    import ffha_pkg::*;

    logic     cfg_we;
    heap_t    cfg_heap;
    logic     start;
    cmd_t     cmd_word;
    logic     idle;
    logic     done;
    res_t     res;
    mem_req_t mem_req;
    entry_t   mem_rdata;

    logic out_valid_reg, out_valid_next;
    res_t out_data_reg, out_data_next;
    logic pend_valid_reg, pend_valid_next;
    res_t pend_data_reg, pend_data_next;
    logic take;

    // configuration: clamp heap size into the supported range
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;
    always_comb
    begin
        if (cfg.heap_size < HEAP_W'(MIN_HEAP))
        begin
            cfg_heap = HEAP_W'(MIN_HEAP);
        end
        else if (cfg.heap_size > HEAP_W'(HEAP_BYTES))
        begin
            cfg_heap = HEAP_W'(HEAP_BYTES);
        end
        else
        begin
            cfg_heap = cfg.heap_size;
        end
    end

    // command side: take a word only when the sequencer idles and the spare
    // slot is empty, so a finishing result always has somewhere to go
    assign cmd.ready              = idle && !pend_valid_reg;
    assign start                  = cmd.valid && cmd.ready;
    assign cmd_word.command       = cmd.command;
    assign cmd_word.request_bytes = cmd.request_bytes;
    assign cmd_word.free_offset   = cmd.free_offset;

    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_heap  (cfg_heap),
        .start     (start),
        .cmd       (cmd_word),
        .idle      (idle),
        .done      (done),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    ffha_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // result side: output register plus one spare slot
    assign take = out_valid_reg && rsp.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        if (!out_valid_reg || take)
        begin
            if (pend_valid_reg)
            begin
                // advance the held result
                out_valid_next  = 1'b1;
                out_data_next   = pend_data_reg;
                pend_valid_next = 1'b0;
            end
            else if (done)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (done)
        begin
            // hold the new result behind the waiting one
            pend_valid_next = 1'b1;
            pend_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        pend_data_reg <= pend_data_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.payload_offset = out_data_reg.payload_offset;
    assign rsp.status         = out_data_reg.status;

endmodule

// ===== src/ffha_store.sv =====
// ----------------------------------------------------------------------------
// ffha_store
// Block header store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffha_store (
    input  logic              clk,
    input  ffha_pkg::mem_req_t req,
    output ffha_pkg::entry_t   rdata
);
    import ffha_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer: clearing sweep, first-fit walk with split, free with coalescing.
// ----------------------------------------------------------------------------
module ffha_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  ffha_pkg::heap_t    cfg_heap,
    input  logic               start,
    input  ffha_pkg::cmd_t     cmd,
    output logic               idle,
    output logic               done,
    output ffha_pkg::res_t     res,
    output ffha_pkg::mem_req_t mem_req,
    input  ffha_pkg::entry_t   mem_rdata
);
    import ffha_pkg::*;

    state_t state_reg, state_next;
    heap_t  heap_reg, heap_next;
    addr_t  clr_reg, clr_next;
    off_t   h_reg, h_next;
    heap_t  need_reg, need_next;
    off_t   sz_reg, sz_next;
    off_t   n_reg, n_next;
    off_t   walk_reg, walk_next;

    entry_t            e;
    logic [HEAP_W:0]   heap18;
    logic [HEAP_W:0]   e_size18;
    logic [HEAP_W:0]   chain_nxt;
    logic [HEAP_W:0]   walk_nxt;
    logic              fit;
    logic              split;
    heap_t             need_in;
    off_t              f_hdr;
    logic              f_bad;
    off_t              merged;

    assign e         = mem_rdata;
    assign heap18    = {1'b0, heap_reg};
    assign e_size18  = {2'b0, e.size};
    assign chain_nxt = {2'b0, h_reg} + (HEAP_W+1)'(HEADER_BYTES) + e_size18;
    assign walk_nxt  = {2'b0, walk_reg} + (HEAP_W+1)'(HEADER_BYTES) + e_size18;
    assign fit       = e.free && ({1'b0, e.size} >= need_reg);
    assign split     = e_size18 >= ({1'b0, need_reg} + (HEAP_W+1)'(MIN_HEAP));
    assign need_in   = ({1'b0, cmd.request_bytes} + HEAP_W'(7)) & ~HEAP_W'(7);
    assign f_hdr     = cmd.free_offset - OFF_W'(HEADER_BYTES);
    assign f_bad     = (cmd.free_offset < OFF_W'(HEADER_BYTES))
                    || ({1'b0, f_hdr} >= heap_reg)
                    || (f_hdr[1:0] != 2'b00);
    assign merged    = sz_reg + OFF_W'(HEADER_BYTES) + e.size;
    assign idle      = (state_reg == S_IDLE);

    // next state and working registers
    always_comb
    begin
        state_next = state_reg;
        heap_next  = heap_reg;
        clr_next   = clr_reg;
        h_next     = h_reg;
        need_next  = need_reg;
        sz_next    = sz_reg;
        n_next     = n_reg;
        walk_next  = walk_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + addr_t'(1);
                if (clr_reg == addr_t'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.command == CMD_ALLOC)
                    begin
                        if (cmd.request_bytes != '0)
                        begin
                            need_next  = need_in;
                            h_next     = '0;
                            state_next = S_A_WALK;
                        end
                    end
                    else if (cmd.free_offset != '0 && !f_bad)
                    begin
                        h_next     = f_hdr;
                        state_next = S_F_HEAD;
                    end
                end
            end
            S_A_WALK:
            begin
                if (fit)
                begin
                    state_next = split ? S_A_SPLIT : S_IDLE;
                end
                else if (chain_nxt >= heap18)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    h_next = chain_nxt[OFF_W-1:0];
                end
            end
            S_A_SPLIT:
            begin
                state_next = S_IDLE;
            end
            S_F_HEAD:
            begin
                sz_next = e.size;
                if (!e.used || e.free)
                begin
                    state_next = S_IDLE;
                end
                else if (chain_nxt < heap18)
                begin
                    n_next     = chain_nxt[OFF_W-1:0];
                    state_next = S_F_NEXT;
                end
                else
                begin
                    walk_next  = '0;
                    state_next = (h_reg == '0) ? S_IDLE : S_F_WALK;
                end
            end
            S_F_NEXT:
            begin
                if (e.free)
                begin
                    sz_next    = merged;
                    state_next = S_F_HW;
                end
                else
                begin
                    walk_next  = '0;
                    state_next = (h_reg == '0) ? S_IDLE : S_F_WALK;
                end
            end
            S_F_HW:
            begin
                walk_next  = '0;
                state_next = (h_reg == '0) ? S_IDLE : S_F_WALK;
            end
            S_F_WALK:
            begin
                if (walk_nxt < {2'b0, h_reg})
                begin
                    walk_next = walk_nxt[OFF_W-1:0];
                end
                else if (walk_nxt == {2'b0, h_reg} && e.free)
                begin
                    state_next = S_F_PW;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_F_PW:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
        if (cfg_we)
        begin
            heap_next  = cfg_heap;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    // memory requests and results
    always_comb
    begin
        mem_req.we    = 1'b0;
        mem_req.waddr = addr_of(h_reg);
        mem_req.wdata = '0;
        mem_req.raddr = addr_of(h_reg);
        done          = 1'b0;
        res.payload_offset = '0;
        res.status    = STAT_OK;
        case (state_reg)
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_reg;
                mem_req.wdata = (clr_reg == '0)
                    ? mk_entry(1'b1, 1'b1, heap_reg[OFF_W-1:0] - OFF_W'(HEADER_BYTES))
                    : '0;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.command == CMD_ALLOC)
                    begin
                        mem_req.raddr = '0;
                        if (cmd.request_bytes == '0)
                        begin
                            done       = 1'b1;
                            res.status = STAT_ZERO;
                        end
                    end
                    else
                    begin
                        mem_req.raddr = addr_of(f_hdr);
                        if (cmd.free_offset == '0)
                        begin
                            done       = 1'b1;
                            res.status = STAT_NULL;
                        end
                        else if (f_bad)
                        begin
                            done       = 1'b1;
                            res.status = STAT_INVALID;
                        end
                    end
                end
            end
            S_A_WALK:
            begin
                mem_req.raddr = addr_of(chain_nxt[OFF_W-1:0]);
                if (fit)
                begin
                    mem_req.we = 1'b1;
                    if (split)
                    begin
                        mem_req.waddr = addr_of(h_reg + OFF_W'(HEADER_BYTES)
                                                + need_reg[OFF_W-1:0]);
                        mem_req.wdata = mk_entry(1'b1, 1'b1, e.size - need_reg[OFF_W-1:0]
                                                 - OFF_W'(HEADER_BYTES));
                    end
                    else
                    begin
                        mem_req.wdata      = mk_entry(1'b1, 1'b0, e.size);
                        done               = 1'b1;
                        res.payload_offset = h_reg + OFF_W'(HEADER_BYTES);
                    end
                end
                else if (chain_nxt >= heap18)
                begin
                    done       = 1'b1;
                    res.status = STAT_OOM;
                end
            end
            S_A_SPLIT:
            begin
                mem_req.we         = 1'b1;
                mem_req.wdata      = mk_entry(1'b1, 1'b0, need_reg[OFF_W-1:0]);
                done               = 1'b1;
                res.payload_offset = h_reg + OFF_W'(HEADER_BYTES);
            end
            S_F_HEAD:
            begin
                if (!e.used)
                begin
                    done       = 1'b1;
                    res.status = STAT_INVALID;
                end
                else if (e.free)
                begin
                    done       = 1'b1;
                    res.status = STAT_DOUBLE;
                end
                else if (chain_nxt < heap18)
                begin
                    mem_req.raddr = addr_of(chain_nxt[OFF_W-1:0]);
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = mk_entry(1'b1, 1'b1, e.size);
                    mem_req.raddr = '0;
                    done          = (h_reg == '0);
                end
            end
            S_F_NEXT:
            begin
                mem_req.we    = 1'b1;
                mem_req.raddr = '0;
                if (e.free)
                begin
                    mem_req.waddr = addr_of(n_reg);
                    mem_req.wdata = '0;
                end
                else
                begin
                    mem_req.wdata = mk_entry(1'b1, 1'b1, sz_reg);
                    done          = (h_reg == '0);
                end
            end
            S_F_HW:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = mk_entry(1'b1, 1'b1, sz_reg);
                mem_req.raddr = '0;
                done          = (h_reg == '0);
            end
            S_F_WALK:
            begin
                mem_req.raddr = addr_of(walk_nxt[OFF_W-1:0]);
                if (walk_nxt < {2'b0, h_reg})
                begin
                    done = 1'b0;
                end
                else if (walk_nxt == {2'b0, h_reg} && e.free)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = addr_of(walk_reg);
                    mem_req.wdata = mk_entry(1'b1, 1'b1, merged);
                end
                else
                begin
                    done = 1'b1;
                end
            end
            S_F_PW:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = '0;
                done          = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            heap_reg  <= HEAP_W'(HEAP_BYTES);
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            heap_reg  <= heap_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        need_reg <= need_next;
        sz_reg   <= sz_next;
        n_reg    <= n_next;
        walk_reg <= walk_next;
    end

endmodule

// ===== tb/tb_first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Self-checking bench for the first-fit heap allocator. A directed table runs
// first, then random allocate/free traffic under several heap sizes. Every
// accepted word is run through a local model of the block list, and each
// result is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    localparam logic [31:0] BLK_START = 32'h8000_0000;
    localparam logic [31:0] BLK_FREE  = 32'h4000_0000;
    localparam logic [31:0] BLK_SIZE  = 32'h3FFF_FFFF;

    logic clk;
    logic rst_n;

    ffha_cfg_if cfg ();
    ffha_cmd_if cmd ();
    ffha_rsp_if rsp ();

    first_fit_heap_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .cmd   (cmd.sink),
        .rsp   (rsp.source)
    );

    // one row of the directed table; typed expectations only where obvious
    typedef struct {
        command_t op;
        int       req;
        int       off;
        bit       typed;
        int       exp_off;
        status_t  exp_st;
    } row_t;

    row_t        directed_rows [$];
    res_t        pending_results [$];
    int          live_offsets [$];
    int          freed_offsets [$];
    int          errors;
    int          results_seen;

    // model of the heap: header word per byte offset, sparse
    logic [31:0] heap_hdr [int];
    int          heap_bytes;

    // ------------------------------------------------------------------
    // Clock, reset and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Heap model
    // ------------------------------------------------------------------
    function automatic logic [31:0] hdr_at(int h);
        return heap_hdr.exists(h) ? heap_hdr[h] : 32'd0;
    endfunction

    function automatic int next_hdr(int h);
        return h + HEADER_BYTES + int'(hdr_at(h) & BLK_SIZE);
    endfunction

    // clamp the written size, then leave a single free block
    function automatic void heap_init(int value);
        int v;
        v = value & 32'h1FFFF;
        if (v < MIN_HEAP)
            v = MIN_HEAP;
        if (v > HEAP_BYTES)
            v = HEAP_BYTES;
        heap_bytes = v;
        heap_hdr.delete();
        heap_hdr[0] = BLK_START | BLK_FREE | (32'(v - HEADER_BYTES) & BLK_SIZE);
    endfunction

    function automatic res_t heap_alloc(int req);
        res_t r;
        int   need;
        int   h;
        int   sz;
        r.payload_offset = '0;
        if (req == 0)
        begin
            r.status = STAT_ZERO;
            return r;
        end
        need = (req + 7) & ~7;
        h = 0;
        while (h < heap_bytes)
        begin
            sz = int'(hdr_at(h) & BLK_SIZE);
            if ((hdr_at(h) & BLK_FREE) != 0 && sz >= need)
            begin
                // split only when the rest holds a header and 8 bytes
                if (sz >= need + HEADER_BYTES + 8)
                begin
                    heap_hdr[h + HEADER_BYTES + need] = BLK_START | BLK_FREE |
                        (32'(sz - need - HEADER_BYTES) & BLK_SIZE);
                    sz = need;
                end
                heap_hdr[h] = BLK_START | (32'(sz) & BLK_SIZE);
                r.payload_offset = off_t'(h + HEADER_BYTES);
                r.status = STAT_OK;
                return r;
            end
            h = next_hdr(h);
        end
        r.status = STAT_OOM;
        return r;
    endfunction

    function automatic res_t heap_free(int p);
        res_t r;
        int   h;
        int   n;
        int   sz;
        int   prev;
        int   walk;
        bit   have_prev;
        r.payload_offset = '0;
        have_prev = 1'b0;
        if (p == 0)
        begin
            r.status = STAT_NULL;
            return r;
        end
        if (p < HEADER_BYTES)
        begin
            r.status = STAT_INVALID;
            return r;
        end
        h = p - HEADER_BYTES;
        if (h >= heap_bytes || (hdr_at(h) & BLK_START) == 0)
        begin
            r.status = STAT_INVALID;
            return r;
        end
        if ((hdr_at(h) & BLK_FREE) != 0)
        begin
            r.status = STAT_DOUBLE;
            return r;
        end
        // merge with a free successor first
        sz = int'(hdr_at(h) & BLK_SIZE);
        n = next_hdr(h);
        if (n < heap_bytes && (hdr_at(n) & BLK_FREE) != 0)
        begin
            sz += HEADER_BYTES + int'(hdr_at(n) & BLK_SIZE);
            heap_hdr.delete(n);
        end
        heap_hdr[h] = BLK_START | BLK_FREE | (32'(sz) & BLK_SIZE);
        // then walk from the start to find the predecessor
        prev = 0;
        walk = 0;
        while (walk < h)
        begin
            prev = walk;
            have_prev = 1'b1;
            walk = next_hdr(walk);
        end
        if (have_prev && walk == h && (hdr_at(prev) & BLK_FREE) != 0)
        begin
            heap_hdr[prev] = BLK_START | BLK_FREE |
                (32'(int'(hdr_at(prev) & BLK_SIZE) + HEADER_BYTES + sz) & BLK_SIZE);
            heap_hdr.delete(h);
        end
        r.status = STAT_OK;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then long
    // ------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    bit no_idle;

    // offer one word, hold it until taken, then predict its result
    task automatic send_word(command_t op, int req, int off, bit typed,
                             int exp_off, status_t exp_st);
        res_t predicted;
        res_t typed_res;
        int   gap;
        cmd.valid         <= 1'b1;
        cmd.command       <= op;
        cmd.request_bytes <= off_t'(req);
        cmd.free_offset   <= off_t'(off);
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (op == CMD_ALLOC)
            predicted = heap_alloc(req & 32'hFFFF);
        else
            predicted = heap_free(off & 32'hFFFF);
        if (typed)
        begin
            typed_res.payload_offset = off_t'(exp_off);
            typed_res.status = exp_st;
            pending_results.push_back(typed_res);
        end
        else
            pending_results.push_back(predicted);
        if (op == CMD_ALLOC && predicted.status == STAT_OK)
            live_offsets.push_back(int'(predicted.payload_offset));
        gap = no_idle ? 0 : idle_len();
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // write heap_size only once the block has drained
    task automatic write_heap_size(int value);
        cmd.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg.valid     <= 1'b1;
        cfg.heap_size <= value[16:0];
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        heap_init(value);
        live_offsets.delete();
        freed_offsets.delete();
    endtask

    task automatic add_row(command_t op, int req, int off, bit typed,
                           int exp_off, status_t exp_st);
        row_t r;
        r.op = op;
        r.req = req;
        r.off = off;
        r.typed = typed;
        r.exp_off = exp_off;
        r.exp_st = exp_st;
        directed_rows.push_back(r);
    endtask

    // one random word, mostly well-formed traffic on the live blocks
    task automatic random_word(int hs);
        int r;
        int k;
        int req;
        int lim;
        r = $urandom_range(0, 99);
        if (r < 50 || live_offsets.size() == 0 && r < 85)
        begin
            k = $urandom_range(0, 99);
            lim = (hs / 16 > 1) ? hs / 16 : 1;
            if (k < 65)
                req = $urandom_range(1, lim);
            else if (k < 80)
                req = $urandom_range(1, 64);
            else if (k < 90)
                req = $urandom_range(1, hs);
            else if (k < 95)
                req = 0;
            else
                req = $urandom_range(0, 65535);
            send_word(CMD_ALLOC, req & 32'hFFFF, $urandom_range(0, 65535), 1'b0, 0, STAT_OK);
        end
        else if (r < 85)
        begin
            k = $urandom_range(0, live_offsets.size() - 1);
            freed_offsets.push_back(live_offsets[k]);
            send_word(CMD_FREE, $urandom_range(0, 65535), live_offsets[k], 1'b0, 0, STAT_OK);
            live_offsets.delete(k);
        end
        else if (r < 90 && freed_offsets.size() != 0)
        begin
            // stale offset: double free, merged-away header, or reused block
            k = $urandom_range(0, freed_offsets.size() - 1);
            send_word(CMD_FREE, 0, freed_offsets[k], 1'b0, 0, STAT_OK);
        end
        else if (r < 96)
            send_word(CMD_FREE, 0, $urandom_range(0, 65535), 1'b0, 0, STAT_OK);
        else
            send_word(CMD_FREE, 0, $urandom_range(0, 1) ? 0 : $urandom_range(1, 40),
                      1'b0, 0, STAT_OK);
    endtask

    int heap_plan [] = '{28, 29, 100, 1024, 8000, 65536, 131071, 0, 512, 3000};

    initial
    begin
        int n;
        int wait_cycles;
        errors = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.heap_size = '0;
        cmd.valid = 1'b0;
        cmd.command = CMD_ALLOC;
        cmd.request_bytes = '0;
        cmd.free_offset = '0;
        heap_init(HEAP_BYTES);

        // directed rows on the reset heap of 65536 bytes
        add_row(CMD_ALLOC, 0,     0,     1, 0,  STAT_ZERO);
        add_row(CMD_ALLOC, 1,     0,     1, 20, STAT_OK);
        add_row(CMD_FREE,  0,     0,     1, 0,  STAT_NULL);
        add_row(CMD_FREE,  0,     5,     1, 0,  STAT_INVALID);
        add_row(CMD_FREE,  0,     20,    1, 0,  STAT_OK);
        add_row(CMD_FREE,  0,     20,    1, 0,  STAT_DOUBLE);
        add_row(CMD_ALLOC, 65535, 0,     1, 0,  STAT_OOM);
        add_row(CMD_ALLOC, 65516, 0,     1, 0,  STAT_OOM);
        add_row(CMD_ALLOC, 65509, 0,     1, 20, STAT_OK);
        add_row(CMD_ALLOC, 1,     0,     1, 0,  STAT_OOM);
        add_row(CMD_FREE,  0,     20,    1, 0,  STAT_OK);
        add_row(CMD_ALLOC, 8,     0,     1, 20, STAT_OK);
        add_row(CMD_ALLOC, 16,    0,     1, 48, STAT_OK);
        add_row(CMD_ALLOC, 9,     65535, 0, 0,  STAT_OK);
        add_row(CMD_FREE,  0,     20,    1, 0,  STAT_OK);
        add_row(CMD_FREE,  0,     48,    1, 0,  STAT_OK);
        add_row(CMD_FREE,  0,     48,    1, 0,  STAT_INVALID);
        add_row(CMD_FREE,  0,     65535, 1, 0,  STAT_INVALID);
        add_row(CMD_FREE,  0,     21,    1, 0,  STAT_INVALID);
        add_row(CMD_FREE,  0,     19,    1, 0,  STAT_INVALID);
        add_row(CMD_ALLOC, 65508, 0,     1, 0,  STAT_OOM);
        add_row(CMD_FREE,  65535, 20,    1, 0,  STAT_DOUBLE);
        add_row(CMD_FREE,  0,     76,    0, 0,  STAT_OK);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].req, directed_rows[i].off,
                      directed_rows[i].typed, directed_rows[i].exp_off,
                      directed_rows[i].exp_st);

        // random traffic, one phase per heap size
        foreach (heap_plan[p])
        begin
            write_heap_size(heap_plan[p]);
            no_idle = (p % 4 == 1);
            n = (heap_plan[p] >= 8000 || heap_plan[p] == 0) ? 150 : 150;
            repeat (n)
                random_word(heap_bytes);
        end
        cmd.valid <= 1'b0;

        // drain, then give the block time to show anything unexpected
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold-off to fill the block
    // ------------------------------------------------------------------
    int hold_left = 0;
    bit hold_done = 1'b0;

    initial
    begin
        rsp.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        res_t exp_res;
        if (rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: payload_offset %0d, status %0d",
                       rsp.payload_offset, rsp.status);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (rsp.payload_offset !== exp_res.payload_offset)
                begin
                    $error("payload_offset: expected %0d, actual %0d",
                           exp_res.payload_offset, rsp.payload_offset);
                    errors++;
                end
                if (rsp.status !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           exp_res.status, rsp.status);
                    errors++;
                end
            end
        end
        // start the long hold-off once traffic is flowing
        if (!hold_done && results_seen == 400)
        begin
            hold_done <= 1'b1;
            hold_left <= 300;
            rsp.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else if (no_idle)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(0, 99) < 70) ||
                         (idle_len() == 0 && $urandom_range(0, 1) == 1);
    end

endmodule

// ===== first_fit_heap_allocator.f =====
src/ffha_pkg.sv
src/ffha_if.sv
src/ffha_store.sv
src/ffha_ctrl.sv
src/first_fit_heap_allocator.sv
tb/tb_first_fit_heap_allocator.sv
